// ----- rtl/json_string_unescape_core_defines.svh -----
// Assertion macros for the JSON string unescape core.
// Each macro takes a label, the clock, the reset, a condition and a consequence.
`ifndef JSON_STRING_UNESCAPE_CORE_DEFINES_SVH
`define JSON_STRING_UNESCAPE_CORE_DEFINES_SVH

`ifndef SYNTH

// The consequence must hold in the same cycle as the condition.
`define JSU_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("jsu assertion failed");

// The consequence must hold in the cycle after the condition.
`define JSU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("jsu assertion failed");

`else

`define JSU_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define JSU_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/jsu_pkg.sv -----
package jsu_pkg;

  // Decoder phase. The code left over in three bits is never entered and acts as idle.
  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_BODY = 3'd1,
    PH_ESC  = 3'd2,
    PH_HEX0 = 3'd3,
    PH_HEX1 = 3'd4,
    PH_HEX2 = 3'd5,
    PH_HEX3 = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    OC_CONT  = 2'd0,
    OC_CLOSE = 2'd1,
    OC_ERROR = 2'd2
  } outcome_t;

  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_U         = 8'h75;
  localparam logic [7:0] CTRL_LIMIT   = 8'h20;
  localparam logic [7:0] U_ESC_MAX    = 8'h7F;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_digit_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] ch;
  } esc_char_t;

  function automatic hex_digit_t hex_digit(input logic [7:0] b);
    hex_digit_t r;
    r.ok  = 1'b1;
    r.val = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r.val = b[3:0];
    end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
      // Letters a..f and A..F share their low bits: 1..6 maps to 10..15.
      r.val = b[3:0] + 4'd9;
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

  function automatic esc_char_t escape_char(input logic [7:0] b);
    esc_char_t r;
    r.ok = 1'b1;
    case (b)
      CH_QUOTE:     r.ch = CH_QUOTE;
      CH_BACKSLASH: r.ch = CH_BACKSLASH;
      CH_SLASH:     r.ch = CH_SLASH;
      8'h62:        r.ch = 8'h08;
      8'h66:        r.ch = 8'h0C;
      8'h6E:        r.ch = 8'h0A;
      8'h72:        r.ch = 8'h0D;
      8'h74:        r.ch = 8'h09;
      default: begin
        r.ok = 1'b0;
        r.ch = 8'h00;
      end
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/json_string_unescape_core.sv -----
// Channel  | Handshake           | Payload
// ---------+---------------------+---------------------------------
// input    | in_valid, in_ready  | data_byte[7:0], final_byte
// result   | out_valid, out_ready| char_valid, out_char[7:0], outcome[1:0]
//
// One result item for every input item, one item per cycle when neither side stalls.
// An accepted item waits in the input register and is decoded into the result
// register once that register can take it, and out_valid rises with the result.
// The phase and hex registers are updated once per decoded byte.
// Reset (rst, synchronous) empties both registers and returns the decoder to idle.
// A stalled result holds the input register, and in_ready falls only when both are full.

`include "json_string_unescape_core_defines.svh"

module json_string_unescape_core
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       final_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       char_valid,
  output logic [7:0] out_char,
  output logic [1:0] outcome
);

  // Input register: the byte waiting to be decoded.
  logic       held_valid;
  logic [7:0] held_byte;
  logic       held_final;

  // Decoder state.
  phase_t      phase, phase_next;
  logic [11:0] hex_accum, hex_accum_next;

  // Decoded result of the held byte.
  logic       res_valid;
  logic [7:0] res_char;
  outcome_t   res_outcome;
  hex_digit_t digit;
  esc_char_t  esc;

  logic advance;

  // The result register can take a new item when it is empty or is being drained.
  assign advance  = !out_valid || out_ready;
  assign in_ready = !held_valid || advance;

  assign digit = hex_digit(held_byte);
  assign esc   = escape_char(held_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      held_byte  <= data_byte;
      held_final <= final_byte;
    end
  end

  // Result of the held byte, given the current phase.
  always_comb begin
    res_valid   = 1'b0;
    res_char    = 8'h00;
    res_outcome = OC_CONT;
    case (phase)
      PH_BODY: begin
        if (held_byte == CH_QUOTE) begin
          res_outcome = OC_CLOSE;
        end else if (held_byte == CH_BACKSLASH) begin
          res_outcome = OC_CONT;
        end else if (held_byte < CTRL_LIMIT) begin
          res_outcome = OC_ERROR;
        end else begin
          res_valid = 1'b1;
          res_char  = held_byte;
        end
      end
      PH_ESC: begin
        if (held_byte == CH_U) begin
          res_outcome = OC_CONT;
        end else if (esc.ok) begin
          res_valid = 1'b1;
          res_char  = esc.ch;
        end else begin
          res_outcome = OC_ERROR;
        end
      end
      PH_HEX0, PH_HEX1, PH_HEX2: begin
        if (!digit.ok) begin
          res_outcome = OC_ERROR;
        end
      end
      PH_HEX3: begin
        // The first three digits must leave the value within plain ASCII.
        if (!digit.ok || hex_accum > {8'd0, U_ESC_MAX[7:4]}) begin
          res_outcome = OC_ERROR;
        end else begin
          res_valid = 1'b1;
          res_char  = {hex_accum[3:0], digit.val};
        end
      end
      default: begin
        if (held_byte != CH_QUOTE) begin
          res_outcome = OC_ERROR;
        end
      end
    endcase
    // A string that ends before its closing quote is malformed.
    if (held_final && res_outcome == OC_CONT) begin
      res_outcome = OC_ERROR;
    end
    if (res_outcome != OC_CONT) begin
      res_valid = 1'b0;
      res_char  = 8'h00;
    end
  end

  // Next phase and hex accumulator.
  always_comb begin
    phase_next     = phase;
    hex_accum_next = hex_accum;
    case (phase)
      PH_BODY: begin
        if (held_byte == CH_BACKSLASH) begin
          phase_next = PH_ESC;
        end
      end
      PH_ESC: begin
        if (held_byte == CH_U) begin
          phase_next     = PH_HEX0;
          hex_accum_next = 12'd0;
        end else begin
          phase_next = PH_BODY;
        end
      end
      PH_HEX0: begin
        phase_next     = PH_HEX1;
        hex_accum_next = {hex_accum[7:0], digit.val};
      end
      PH_HEX1: begin
        phase_next     = PH_HEX2;
        hex_accum_next = {hex_accum[7:0], digit.val};
      end
      PH_HEX2: begin
        phase_next     = PH_HEX3;
        hex_accum_next = {hex_accum[7:0], digit.val};
      end
      PH_HEX3: begin
        phase_next = PH_BODY;
      end
      default: begin
        phase_next = PH_BODY;
      end
    endcase
    // Any close or error ends the string and returns to idle.
    if (res_outcome != OC_CONT) begin
      phase_next     = PH_IDLE;
      hex_accum_next = 12'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      hex_accum <= 12'd0;
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= held_valid;
      if (held_valid) begin
        phase     <= phase_next;
        hex_accum <= hex_accum_next;
      end
    end
    if (advance && held_valid) begin
      char_valid <= res_valid;
      out_char   <= res_char;
      outcome    <= res_outcome;
    end
  end

  // A close or an error never carries a character.
  `JSU_ASSERT_SAME(a_end_no_char, clk, rst, out_valid && outcome != OC_CONT,
                   !char_valid && out_char == 8'h00)
  // Closing the string or an error puts the decoder back in idle.
  `JSU_ASSERT_NEXT(a_end_to_idle, clk, rst, advance && held_valid && res_outcome != OC_CONT,
                   phase == PH_IDLE)
  // The last byte of the input always ends the string.
  `JSU_ASSERT_NEXT(a_final_to_idle, clk, rst, advance && held_valid && held_final, phase == PH_IDLE)
  // A fresh \u sequence starts from an empty accumulator.
  `JSU_ASSERT_SAME(a_hex_start_clear, clk, rst, phase == PH_HEX0, hex_accum == 12'd0)

endmodule
